// File: rtl/ncs_pkg.sv
// Shared types, constants and fixed-point helpers for the natural cubic spline block.
package ncs_pkg;

  localparam int MAX_KNOTS_DEF = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int DATA_W        = 32;
  localparam int WIDE_W        = 64;

  localparam logic signed [DATA_W-1:0] SAT_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [DATA_W-1:0] SAT_MIN = 32'sh8000_0000;

  // request modes
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // result status codes
  localparam logic [1:0] ST_VALUE   = 2'd0;
  localparam logic [1:0] ST_FIT_OK  = 2'd1;
  localparam logic [1:0] ST_FIT_REJ = 2'd2;
  localparam logic [1:0] ST_NO_FIT  = 2'd3;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] abscissa;
    logic signed [DATA_W-1:0] ordinate;
    logic                     last_knot;
  } req_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               status;
  } rsp_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] x;
    logic signed [DATA_W-1:0] y;
  } knot_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] b;
    logic signed [DATA_W-1:0] c;
    logic signed [DATA_W-1:0] d;
    logic signed [DATA_W-1:0] mu;
    logic signed [DATA_W-1:0] z;
  } coef_t;

  typedef struct packed {
    logic                     start;
    logic signed [WIDE_W-1:0] num;
    logic signed [DATA_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [DATA_W-1:0] quo;
  } div_rsp_t;

  function automatic logic signed [WIDE_W-1:0] sx64(input logic signed [DATA_W-1:0] v);
    return {{(WIDE_W-DATA_W){v[DATA_W-1]}}, v};
  endfunction

  function automatic logic signed [DATA_W-1:0] sat32(input logic signed [WIDE_W-1:0] v);
    if (v > sx64(SAT_MAX)) begin
      return SAT_MAX;
    end else if (v < sx64(SAT_MIN)) begin
      return SAT_MIN;
    end
    return v[DATA_W-1:0];
  endfunction

endpackage

// File: rtl/natural_cubic_spline.sv
// Natural cubic spline: knot loading, tridiagonal fit and segment evaluation.
// Usage:
//   One request channel (req_valid / req_stall / req) and one result channel
//   (rsp_valid / rsp_stall / rsp). A load request (mode 0) stores a knot as
//   it is taken and gives no result unless last_knot is set. The last knot
//   closes the set and starts the fit, which answers status 1 (done) or
//   2 (rejected). A query (mode 1) answers the spline value with status 0,
//   or status 3 when no valid fit is held.
//   A divide that saturates or has a zero divisor ends without iterating;
//   the fit runs forward over the inner knots and backward over the
//   segments, paced by the shared divider and the single read port of each
//   memory. A query result waits on a search that reads one segment after
//   another from the first until it finds the segment of the query.
//   A rejected fit goes from the check straight to the emit step, and a
//   query without fit goes to the emit step as it is taken.
//   req_stall is high while a request is at work; one finished result may
//   wait in the output register while the next request is taken, and a
//   later result holds in its emit step until rsp_stall drops.
//   Reset clears the knot count and the fit flag; the knot and coefficient
//   memories need no clearing.
module natural_cubic_spline #(
  parameter int MAX_KNOTS = ncs_pkg::MAX_KNOTS_DEF,
  parameter int FRAC_BITS = ncs_pkg::FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  ncs_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ncs_pkg::rsp_t rsp
);
  import ncs_pkg::*;

  localparam int AW = $clog2(MAX_KNOTS);
  localparam int CW = $clog2(MAX_KNOTS + 2);
  // ceil(2^33 / 3): exact unsigned 32-bit divide by three after a 33-bit shift
  localparam logic [DATA_W-1:0] RECIP3 = 32'hAAAA_AAAB;

  typedef enum logic [5:0] {
    S_IDLE, S_EMIT, S_F_CHK, S_F_RD0, S_F_RD1, S_F_LD1, S_F_RD, S_F_DAT,
    S_F_D1, S_F_D1W, S_F_D2, S_F_D2W, S_F_M1, S_F_L, S_F_D3, S_F_D3W,
    S_F_M2, S_F_R, S_F_D4, S_F_D4W,
    S_B_RD, S_B_DAT, S_B_M1, S_B_C, S_B_M2, S_B_D1, S_B_D2, S_B_D2W,
    S_B_D3, S_B_D3W,
    S_Q_RD, S_Q_CMP, S_Q_RD2, S_Q_DAT, S_Q_M1, S_Q_M2, S_Q_M3, S_Q_M4, S_Q_M5,
    S_Q_M6
  } state_t;

  state_t state;

  // control
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [CW-1:0] n;
  logic [CW-1:0] nm2;
  logic [CW-1:0] fit_n;
  logic [CW-1:0] fmn2;
  logic [CW-1:0] idx;
  logic          bad;
  logic          fit_valid;
  logic          accept;

  // memories and their ports
  knot_t         knot_mem [MAX_KNOTS];
  coef_t         coef_mem [MAX_KNOTS];
  logic [AW-1:0] kaddr;
  logic [AW-1:0] caddr;
  knot_t         kdata;
  coef_t         cdata;
  logic          kw_en;
  logic [AW-1:0] kw_addr;
  knot_t         kw_data;
  logic          cw_en;
  logic [AW-1:0] cw_addr;
  coef_t         cw_data;

  // datapath registers
  logic signed [DATA_W-1:0] prev_x;
  logic signed [DATA_W-1:0] xa, xb, xc, ya, yb, yc;
  logic signed [DATA_W-1:0] mu_p, z_p, t1, alpha, lval, muv, cn, cj, bval;
  logic signed [DATA_W-1:0] qx, dx, dx2;
  logic signed [WIDE_W-1:0] acc;
  logic signed [DATA_W-1:0] res_value;
  logic [1:0]               res_status;

  // shared units
  div_req_t                 dv_req;
  div_rsp_t                 dv_rsp;
  logic signed [DATA_W-1:0] op_a, op_b, mres;
  logic signed [DATA_W-1:0] ha, hb, h3;

  // divide by three
  logic [DATA_W-1:0]        d3_mag;
  logic [WIDE_W-1:0]        d3_prod;
  logic signed [DATA_W-1:0] d3_quo;

  ncs_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk (clk),
    .rst (rst),
    .req (dv_req),
    .rsp (dv_rsp)
  );

  ncs_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
    .clk (clk),
    .a   (op_a),
    .b   (op_b),
    .res (mres)
  );

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;

  // knot spacings and counters
  always_comb begin
    ha         = sat32(sx64(xb) - sx64(xa));
    hb         = sat32(sx64(xc) - sx64(xb));
    h3         = sat32(64'sd3 * sx64(ha));
    count_next = (count < CW'(MAX_KNOTS)) ? count + CW'(1) : CW'(MAX_KNOTS + 1);
    nm2        = n - CW'(2);
    fmn2       = fit_n - CW'(2);
  end

  // truncate the product toward zero over three by reciprocal multiply
  always_comb begin
    d3_mag  = mres[DATA_W-1] ? -mres : mres;
    d3_prod = WIDE_W'(d3_mag) * WIDE_W'(RECIP3);
    d3_quo  = mres[DATA_W-1] ? -$signed({1'b0, d3_prod[WIDE_W-1:DATA_W+1]})
                             : $signed({1'b0, d3_prod[WIDE_W-1:DATA_W+1]});
  end

  // divider request per step
  always_comb begin
    dv_req = '0;
    case (state)
      S_F_D1: begin
        dv_req.start = 1'b1;
        dv_req.num   = 64'sd3 * (sx64(yc) - sx64(yb));
        dv_req.den   = hb;
      end
      S_F_D2: begin
        dv_req.start = 1'b1;
        dv_req.num   = 64'sd3 * (sx64(yb) - sx64(ya));
        dv_req.den   = ha;
      end
      S_F_D3: begin
        dv_req.start = 1'b1;
        dv_req.num   = sx64(hb);
        dv_req.den   = lval;
      end
      S_F_D4: begin
        dv_req.start = 1'b1;
        dv_req.num   = sx64(alpha);
        dv_req.den   = lval;
      end
      S_B_D2: begin
        dv_req.start = 1'b1;
        dv_req.num   = sx64(yb) - sx64(ya);
        dv_req.den   = ha;
      end
      S_B_D3: begin
        dv_req.start = 1'b1;
        dv_req.num   = sx64(cn) - sx64(cj);
        dv_req.den   = h3;
      end
      default: dv_req = '0;
    endcase
  end

  // multiplier operands per step
  always_comb begin
    op_a = '0;
    op_b = '0;
    case (state)
      S_F_M1: begin op_a = ha;      op_b = mu_p; end
      S_F_M2: begin op_a = ha;      op_b = z_p;  end
      S_B_M1: begin op_a = mu_p;    op_b = cn;   end
      S_B_M2: begin op_a = ha;      op_b = sat32(sx64(cn) + 64'sd2 * sx64(cj)); end
      S_Q_M1: begin op_a = dx;      op_b = dx;   end
      S_Q_M2: begin op_a = cdata.b; op_b = dx;   end
      S_Q_M3: begin op_a = dx2;     op_b = dx;   end
      S_Q_M4: begin op_a = cdata.c; op_b = dx2;  end
      S_Q_M5: begin op_a = cdata.d; op_b = lval; end
      default: begin op_a = '0;     op_b = '0;   end
    endcase
  end

  // memory write ports
  always_comb begin
    kw_en        = accept && (req.mode == MODE_LOAD) && (count < CW'(MAX_KNOTS));
    kw_addr      = count[AW-1:0];
    kw_data.x    = req.abscissa;
    kw_data.y    = req.ordinate;
    cw_en        = 1'b0;
    cw_addr      = idx[AW-1:0];
    cw_data      = '0;
    case (state)
      S_F_CHK: begin
        cw_en   = 1'b1;
        cw_addr = '0;
      end
      S_F_D4W: begin
        cw_en      = dv_rsp.done;
        cw_data.mu = muv;
        cw_data.z  = dv_rsp.quo;
      end
      S_B_D3W: begin
        cw_en      = dv_rsp.done;
        cw_data.b  = bval;
        cw_data.c  = cj;
        cw_data.d  = dv_rsp.quo;
        cw_data.mu = mu_p;
        cw_data.z  = z_p;
      end
      default: cw_en = 1'b0;
    endcase
  end

  // knot memory
  always_ff @(posedge clk) begin
    if (kw_en) begin
      knot_mem[kw_addr] <= kw_data;
    end
    kdata <= knot_mem[kaddr];
  end

  // coefficient memory
  always_ff @(posedge clk) begin
    if (cw_en) begin
      coef_mem[cw_addr] <= cw_data;
    end
    cdata <= coef_mem[caddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      bad       <= 1'b0;
      fit_valid <= 1'b0;
      fit_n     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall && state != S_EMIT) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.mode == MODE_QUERY) begin
              qx <= req.abscissa;
              if (!fit_valid) begin
                res_value  <= '0;
                res_status <= ST_NO_FIT;
                state      <= S_EMIT;
              end else begin
                idx   <= '0;
                kaddr <= AW'(1);
                state <= S_Q_RD;
              end
            end else begin
              fit_valid <= 1'b0;
              if (count < CW'(MAX_KNOTS)) begin
                prev_x <= req.abscissa;
                if (count == '0) begin
                  bad <= 1'b0;
                end else if (req.abscissa <= prev_x) begin
                  bad <= 1'b1;
                end
              end
              if (req.last_knot) begin
                n     <= count_next;
                count <= '0;
                state <= S_F_CHK;
              end else begin
                count <= count_next;
              end
            end
          end
        end
        // hold the result until the output register frees
        S_EMIT: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid  <= 1'b1;
            rsp.value  <= res_value;
            rsp.status <= res_status;
            state      <= S_IDLE;
          end
        end
        // reject short, overflowed or unordered sets
        S_F_CHK: begin
          if (n < CW'(2) || n > CW'(MAX_KNOTS) || bad) begin
            res_value  <= '0;
            res_status <= ST_FIT_REJ;
            state      <= S_EMIT;
          end else begin
            kaddr <= '0;
            state <= S_F_RD0;
          end
        end
        S_F_RD0: begin
          kaddr <= AW'(1);
          state <= S_F_RD1;
        end
        S_F_RD1: begin
          xa    <= kdata.x;
          ya    <= kdata.y;
          state <= S_F_LD1;
        end
        S_F_LD1: begin
          xb   <= kdata.x;
          yb   <= kdata.y;
          mu_p <= '0;
          z_p  <= '0;
          if (n == CW'(2)) begin
            cn    <= '0;
            idx   <= '0;
            kaddr <= '0;
            caddr <= '0;
            state <= S_B_RD;
          end else begin
            idx   <= CW'(1);
            kaddr <= AW'(2);
            state <= S_F_RD;
          end
        end
        // forward elimination, one inner knot per pass
        S_F_RD: state <= S_F_DAT;
        S_F_DAT: begin
          xc    <= kdata.x;
          yc    <= kdata.y;
          state <= S_F_D1;
        end
        S_F_D1: state <= S_F_D1W;
        S_F_D1W: begin
          if (dv_rsp.done) begin
            t1    <= dv_rsp.quo;
            state <= S_F_D2;
          end
        end
        S_F_D2: state <= S_F_D2W;
        S_F_D2W: begin
          if (dv_rsp.done) begin
            alpha <= sat32(sx64(t1) - sx64(dv_rsp.quo));
            state <= S_F_M1;
          end
        end
        S_F_M1: state <= S_F_L;
        S_F_L: begin
          lval  <= sat32(64'sd2 * (sx64(xc) - sx64(xa)) - sx64(mres));
          state <= S_F_D3;
        end
        S_F_D3: state <= S_F_D3W;
        S_F_D3W: begin
          if (dv_rsp.done) begin
            muv   <= dv_rsp.quo;
            state <= S_F_M2;
          end
        end
        S_F_M2: state <= S_F_R;
        S_F_R: begin
          alpha <= sat32(sx64(alpha) - sx64(mres));
          state <= S_F_D4;
        end
        S_F_D4: state <= S_F_D4W;
        S_F_D4W: begin
          if (dv_rsp.done) begin
            mu_p <= muv;
            z_p  <= dv_rsp.quo;
            xa   <= xb;
            ya   <= yb;
            xb   <= xc;
            yb   <= yc;
            if (idx == nm2) begin
              cn    <= '0;
              kaddr <= nm2[AW-1:0];
              caddr <= nm2[AW-1:0];
              state <= S_B_RD;
            end else begin
              idx   <= idx + CW'(1);
              kaddr <= idx[AW-1:0] + AW'(2);
              state <= S_F_RD;
            end
          end
        end
        // back substitution, last segment first
        S_B_RD: state <= S_B_DAT;
        S_B_DAT: begin
          xa    <= kdata.x;
          ya    <= kdata.y;
          mu_p  <= cdata.mu;
          z_p   <= cdata.z;
          state <= S_B_M1;
        end
        S_B_M1: state <= S_B_C;
        S_B_C: begin
          cj    <= sat32(sx64(z_p) - sx64(mres));
          state <= S_B_M2;
        end
        S_B_M2: state <= S_B_D1;
        S_B_D1: begin
          t1    <= d3_quo;
          state <= S_B_D2;
        end
        S_B_D2: state <= S_B_D2W;
        S_B_D2W: begin
          if (dv_rsp.done) begin
            bval  <= sat32(sx64(dv_rsp.quo) - sx64(t1));
            state <= S_B_D3;
          end
        end
        S_B_D3: state <= S_B_D3W;
        S_B_D3W: begin
          if (dv_rsp.done) begin
            cn <= cj;
            xb <= xa;
            yb <= ya;
            if (idx == '0) begin
              fit_valid  <= 1'b1;
              fit_n      <= n;
              res_value  <= '0;
              res_status <= ST_FIT_OK;
              state      <= S_EMIT;
            end else begin
              idx   <= idx - CW'(1);
              kaddr <= idx[AW-1:0] - AW'(1);
              caddr <= idx[AW-1:0] - AW'(1);
              state <= S_B_RD;
            end
          end
        end
        // search for the first right knot above the query
        S_Q_RD: state <= S_Q_CMP;
        S_Q_CMP: begin
          if (qx < kdata.x || idx == fmn2) begin
            kaddr <= idx[AW-1:0];
            caddr <= idx[AW-1:0];
            state <= S_Q_RD2;
          end else begin
            idx   <= idx + CW'(1);
            kaddr <= idx[AW-1:0] + AW'(2);
            state <= S_Q_RD;
          end
        end
        S_Q_RD2: state <= S_Q_DAT;
        S_Q_DAT: begin
          dx    <= sat32(sx64(qx) - sx64(kdata.x));
          ya    <= kdata.y;
          state <= S_Q_M1;
        end
        // evaluate the cubic, one product a cycle
        S_Q_M1: state <= S_Q_M2;
        S_Q_M2: begin
          dx2   <= mres;
          state <= S_Q_M3;
        end
        S_Q_M3: begin
          acc   <= sx64(ya) + sx64(mres);
          state <= S_Q_M4;
        end
        S_Q_M4: begin
          lval  <= mres;
          state <= S_Q_M5;
        end
        S_Q_M5: begin
          acc   <= acc + sx64(mres);
          state <= S_Q_M6;
        end
        S_Q_M6: begin
          res_value  <= sat32(acc + sx64(mres));
          res_status <= ST_VALUE;
          state      <= S_EMIT;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: rtl/ncs_div.sv
// Iterative signed fixed-point divider: (num << FRAC_BITS) / den, truncated and saturated.
module ncs_div #(
  parameter int FRAC_BITS = ncs_pkg::FRAC_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ncs_pkg::div_req_t req,
  output ncs_pkg::div_rsp_t rsp
);
  import ncs_pkg::*;

  localparam int QW = DATA_W - 1;
  localparam int SW = $clog2(QW + 1);

  logic signed [WIDE_W-1:0] num_sh;
  logic [WIDE_W-1:0]        num_mag;
  logic [DATA_W-1:0]        den_mag;
  logic                     num_neg;
  logic                     den_neg;
  logic                     ovf;
  logic [DATA_W:0]          trial;
  logic [DATA_W:0]          diff;
  logic                     ge;
  logic [QW-1:0]            q_fin;

  logic                     busy;
  logic                     done;
  logic                     neg;
  logic [SW-1:0]            steps;
  logic [DATA_W-1:0]        dmag;
  logic [DATA_W-1:0]        rem;
  logic [QW-1:0]            low;
  logic [QW-1:0]            qacc;
  logic signed [DATA_W-1:0] quo;

  // magnitudes, overflow test and one restoring step
  always_comb begin
    num_sh  = req.num <<< FRAC_BITS;
    num_neg = req.num[WIDE_W-1];
    num_mag = num_neg ? -num_sh : num_sh;
    den_neg = req.den[DATA_W-1];
    den_mag = den_neg ? -req.den : req.den;
    ovf     = num_mag >= {1'b0, den_mag, {QW{1'b0}}};
    trial   = {rem, low[QW-1]};
    diff    = trial - {1'b0, dmag};
    ge      = trial >= {1'b0, dmag};
    q_fin   = {qacc[QW-2:0], ge};
  end

  // start, iterate one quotient bit a cycle, finish
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        neg <= num_neg ^ den_neg;
        if (req.den == '0) begin
          done <= 1'b1;
          if (req.num == '0) begin
            quo <= '0;
          end else begin
            quo <= num_neg ? SAT_MIN : SAT_MAX;
          end
        end else if (ovf) begin
          done <= 1'b1;
          quo  <= (num_neg ^ den_neg) ? SAT_MIN : SAT_MAX;
        end else begin
          busy  <= 1'b1;
          dmag  <= den_mag;
          rem   <= num_mag[WIDE_W-2 -: DATA_W];
          low   <= num_mag[QW-1:0];
          steps <= SW'(QW);
        end
      end else if (busy) begin
        rem   <= ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        low   <= {low[QW-2:0], 1'b0};
        qacc  <= q_fin;
        steps <= steps - SW'(1);
        if (steps == SW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
          quo  <= neg ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
        end
      end
    end
  end

  always_comb begin
    rsp.done = done;
    rsp.quo  = quo;
  end

endmodule

// File: rtl/ncs_mul.sv
// Registered fixed-point multiplier with floor rounding and saturation.
module ncs_mul #(
  parameter int FRAC_BITS = ncs_pkg::FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic signed [ncs_pkg::DATA_W-1:0] a,
  input  logic signed [ncs_pkg::DATA_W-1:0] b,
  output logic signed [ncs_pkg::DATA_W-1:0] res
);
  import ncs_pkg::*;

  logic signed [WIDE_W-1:0] prod;

  // capture the full product every cycle
  always_ff @(posedge clk) begin
    prod <= sx64(a) * sx64(b);
  end

  // drop fraction bits toward minus infinity, then clamp
  assign res = sat32(prod >>> FRAC_BITS);

endmodule

// File: rtl/ncs_chk.sv
// Port-level checks for the natural cubic spline block, bound to the top level.
module ncs_chk (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input ncs_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input ncs_pkg::rsp_t rsp
);
  import ncs_pkg::*;

  // a stalled result holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result changed");

  // a query or closing knot keeps the block busy for the next cycle
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.mode == MODE_QUERY || req.last_knot) |=> req_stall)
    else $error("block not busy after query or fit request");

  // after a plain knot load the block is not busy in the next cycle
  a_load: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && req.mode == MODE_LOAD && !req.last_knot |=> !req_stall)
    else $error("block busy after plain knot load");

  // only query values carry a nonzero value
  a_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_VALUE |-> rsp.value == '0)
    else $error("status result with nonzero value");

endmodule

bind natural_cubic_spline ncs_chk u_ncs_chk (.*);
